FILE: sv/assert_macros.svh
// Assertion shorthands for the vertex pipeline.
// Needs clock and reset in the scope of the module that takes it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every edge outside reset
`define HVNT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// antecedent now, consequent at the following edge
`define HVNT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) ante |=> cons) else $error(msg);

`endif

FILE: sv/hvnt_pkg.sv
// Types, constants and per-stage arithmetic for the terrain vertex pipeline.
// No dependencies; used by heightmap_vertex_normal_tangent.
package hvnt_pkg;

   localparam int MAX_LOD       = 4;
   localparam int MAX_GRID_SIDE = 257;
   localparam int MM_PER_M      = 1000;

   localparam int HW     = 24;             // height width
   localparam int MAGW   = 24;             // magnitude of a height difference
   localparam int VW     = 23;             // vertical term
   localparam int SQW    = 2 * MAGW;       // one square
   localparam int SUMW   = SQW + 2;        // sum of three squares
   localparam int NRMW   = 62;             // normalised sum
   localparam int ROOTW  = NRMW / 2;       // root and scaled magnitudes
   localparam int QW     = 16;             // Q1.15 quotient incl. the value one
   localparam int NUMW   = ROOTW + QW;     // rounded dividend
   localparam int POSW   = 27;             // unsaturated position
   localparam int TEXW   = 17;
   localparam int TNUMW  = POSW + 17;      // texture dividend
   localparam int KW     = 5;

   localparam int SQRT_STEPS = ROOTW;
   localparam int DIV_STEPS  = QW;
   localparam int TEX_STEPS  = TEXW;

   localparam int CSRW     = 16;
   localparam int CSR_IDXW = 3;

   localparam logic [10:0] VERT_SCALE = 11'(2 * MM_PER_M);
   localparam logic [TEXW-1:0] UV_ONE = TEXW'(65536);

   typedef enum logic [CSR_IDXW-1:0] {
      CSR_LOD        = 3'd0,
      CSR_SPACING    = 3'd1,
      CSR_CHUNK_EDGE = 3'd2,
      CSR_WORLD_W    = 3'd3,
      CSR_WORLD_D    = 3'd4
   } csr_idx_type;

   typedef struct packed {
      logic [HW-1:0] hc;
      logic [HW-1:0] hl;
      logic [HW-1:0] hr;
      logic [HW-1:0] hd;
      logic [HW-1:0] hu;
      logic [9:0]    cx;
      logic [9:0]    cz;
      logic [8:0]    gx;
      logic [8:0]    gz;
   } in_type;

   // fields that ride along with the word; some are filled in late
   typedef struct packed {
      logic [15:0]     pos_x;
      logic [HW-1:0]   pos_y;
      logic [15:0]     pos_z;
      logic            neg_nx;
      logic            neg_nz;
      logic            neg_ty;
      logic            hand_neg;
      logic [TEXW-1:0] tex_u;
      logic [TEXW-1:0] tex_v;
   } pass_type;

   typedef struct packed {
      pass_type      pass;
      logic [MAGW-1:0] mx;
      logic [MAGW-1:0] mz;
      logic [VW-1:0]   vert;
      logic [25:0]     cxe;
      logic [25:0]     cze;
      logic [16:0]     gxs;
      logic [16:0]     gzs;
   } f1_type;

   typedef struct packed {
      pass_type        pass;
      logic [SQW-1:0]  sqx;
      logic [SQW-1:0]  sqz;
      logic [SQW-1:0]  sqv;
      logic [MAGW-1:0] mx;
      logic [MAGW-1:0] mz;
      logic [VW-1:0]   vert;
      logic [POSW-1:0] px;
      logic [POSW-1:0] pz;
   } f2_type;

   typedef struct packed {
      logic [TNUMW-1:0] rem;
      logic [TEXW-1:0]  q;
      logic             sat;
   } tdiv_type;

   typedef struct packed {
      pass_type        pass;
      logic [SUMW-1:0] sn;
      logic [SUMW-1:0] st;
      logic [MAGW-1:0] mx;
      logic [MAGW-1:0] mz;
      logic [VW-1:0]   vert;
      tdiv_type        tu;
      tdiv_type        tv;
   } f3_type;

   typedef struct packed {
      logic [NRMW-1:0] x;
      logic [NRMW-1:0] r;
   } root_type;

   typedef struct packed {
      logic [NRMW-1:0] s;
      logic [KW-1:0]   k;
   } norm_type;

   typedef struct packed {
      pass_type         pass;
      root_type         rn;
      root_type         rt;
      logic [ROOTW-1:0] mnx;
      logic [ROOTW-1:0] mny;
      logic [ROOTW-1:0] mnz;
      logic [ROOTW-1:0] mtx;
      logic [ROOTW-1:0] mty;
      tdiv_type         tu;
      tdiv_type         tv;
   } sq_type;

   typedef struct packed {
      logic [NUMW-1:0] rem;
      logic [QW-1:0]   q;
   } qdiv_type;

   typedef struct packed {
      pass_type         pass;
      logic [ROOTW-1:0] ln;
      logic [ROOTW-1:0] lt;
      qdiv_type         nx;
      qdiv_type         ny;
      qdiv_type         nz;
      qdiv_type         tx;
      qdiv_type         ty;
   } dv_type;

   typedef struct packed {
      logic [15:0]     pos_x;
      logic [HW-1:0]   pos_y;
      logic [15:0]     pos_z;
      logic [15:0]     nrm_x;
      logic [14:0]     nrm_y;
      logic [15:0]     nrm_z;
      logic [15:0]     tan_x;
      logic [15:0]     tan_y;
      logic [15:0]     tan_z;
      logic            hand_neg;
      logic [TEXW-1:0] tex_u;
      logic [TEXW-1:0] tex_v;
   } res_type;

   // largest even shift that keeps the sum below 2^62, found greedily
   function automatic norm_type norm_shift(logic [SUMW-1:0] s);
      norm_type res;
      res.s = NRMW'(s);
      res.k = '0;
      for (int i = 0; i < KW; i++) begin
         if ((res.s >> (NRMW - 2 * (16 >> i))) == '0) begin
            res.s = res.s << (2 * (16 >> i));
            res.k = res.k + KW'(16 >> i);
         end
      end
      return res;
   endfunction

   // one digit of the restoring square root
   function automatic root_type sqrt_step(root_type cur, int sh);
      logic [NRMW-1:0] bitv;
      logic [NRMW:0]   trial;
      root_type        nxt;
      bitv  = NRMW'(1) << sh;
      trial = {1'b0, cur.r} + {1'b0, bitv};
      if ({1'b0, cur.x} >= trial) begin
         nxt.x = cur.x - trial[NRMW-1:0];
         nxt.r = (cur.r >> 1) + bitv;
      end else begin
         nxt.x = cur.x;
         nxt.r = cur.r >> 1;
      end
      return nxt;
   endfunction

   function automatic tdiv_type tex_step(tdiv_type cur, logic [15:0] d, int b);
      logic [TNUMW-1:0] dsh;
      tdiv_type         nxt;
      nxt = cur;
      dsh = TNUMW'(d) << b;
      if (cur.rem >= dsh) begin
         nxt.rem = cur.rem - dsh;
         nxt.q   = cur.q | (TEXW'(1) << b);
      end
      return nxt;
   endfunction

   function automatic qdiv_type div_step(qdiv_type cur, logic [ROOTW-1:0] d, int b);
      logic [NUMW-1:0] dsh;
      qdiv_type        nxt;
      nxt = cur;
      dsh = NUMW'(d) << b;
      if (cur.rem >= dsh) begin
         nxt.rem = cur.rem - dsh;
         nxt.q   = cur.q | (QW'(1) << b);
      end
      return nxt;
   endfunction

   function automatic sq_type sq_stage(sq_type cur, logic [15:0] du, logic [15:0] dd,
                                       int j);
      sq_type nxt;
      nxt    = cur;
      nxt.rn = sqrt_step(cur.rn, (NRMW - 2) - 2 * j);
      nxt.rt = sqrt_step(cur.rt, (NRMW - 2) - 2 * j);
      if (j < TEX_STEPS) begin
         nxt.tu = tex_step(cur.tu, du, TEX_STEPS - 1 - j);
         nxt.tv = tex_step(cur.tv, dd, TEX_STEPS - 1 - j);
      end
      return nxt;
   endfunction

   function automatic dv_type dv_stage(dv_type cur, int j);
      dv_type nxt;
      nxt    = cur;
      nxt.nx = div_step(cur.nx, cur.ln, DIV_STEPS - 1 - j);
      nxt.ny = div_step(cur.ny, cur.ln, DIV_STEPS - 1 - j);
      nxt.nz = div_step(cur.nz, cur.ln, DIV_STEPS - 1 - j);
      nxt.tx = div_step(cur.tx, cur.lt, DIV_STEPS - 1 - j);
      nxt.ty = div_step(cur.ty, cur.lt, DIV_STEPS - 1 - j);
      return nxt;
   endfunction

   // magnitude plus sign to Q1.15, the value one saturating when positive
   function automatic logic [15:0] to_q15(logic [QW-1:0] q, logic neg);
      if (neg)
         return QW'(~q + 1'b1);
      else if (q[QW-1])
         return 16'h7FFF;
      else
         return q;
   endfunction

endpackage

FILE: sv/heightmap_vertex_normal_tangent.sv
// Terrain vertex pipeline: position, unit normal, unit tangent and uv per grid vertex.
// Depends on hvnt_pkg and assert_macros.svh.
//
// Use: one input word per vertex on req_* (valid/stall), one result word per vertex
// on rsp_* in the same order. csr_* writes the five settings (level of detail,
// spacing, chunk edge, world width and depth); write them only while the pipe is empty.
// Throughput: one word per cycle, no bubbles while rsp_stall stays low.
// After the input register come three stages of differences, squares and sums, a
// normalising stage and the 31 digit stages of the square root, a rounding stage
// and the 16 quotient stages of the normaliser, and the output register.
// Texture divides run in parallel with the root stages.
// Reset clears all valid bits and loads the settings with 0, 1, 256, 4096, 4096.
// Stall: the output register holds a word while rsp_stall is high; one more word lands
// in a skid register, and req_stall rises only once that skid is full, which freezes
// the whole pipe until the output is taken. Nothing is dropped or repeated.
`include "assert_macros.svh"

module heightmap_vertex_normal_tangent (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [23:0]           req_height_center,
   input  logic signed [23:0]           req_height_left,
   input  logic signed [23:0]           req_height_right,
   input  logic signed [23:0]           req_height_down,
   input  logic signed [23:0]           req_height_up,
   input  logic [9:0]                   req_chunk_x,
   input  logic [9:0]                   req_chunk_z,
   input  logic [8:0]                   req_grid_x,
   input  logic [8:0]                   req_grid_z,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [15:0]                  rsp_pos_x,
   output logic signed [23:0]           rsp_pos_y,
   output logic [15:0]                  rsp_pos_z,
   output logic signed [15:0]           rsp_nrm_x,
   output logic [14:0]                  rsp_nrm_y,
   output logic signed [15:0]           rsp_nrm_z,
   output logic signed [15:0]           rsp_tan_x,
   output logic signed [15:0]           rsp_tan_y,
   output logic signed [15:0]           rsp_tan_z,
   output logic                         rsp_handedness_negative,
   output logic [16:0]                  rsp_tex_u,
   output logic [16:0]                  rsp_tex_v,
   input  logic                         csr_wr_en,
   input  logic [hvnt_pkg::CSR_IDXW-1:0] csr_index,
   input  logic [hvnt_pkg::CSRW-1:0]    csr_wdata
);
   import hvnt_pkg::*;

   // settings
   logic [2:0]  lod_ff;
   logic [7:0]  sp_ff;
   logic [15:0] edge_ff;
   logic [15:0] ww_ff;
   logic [15:0] wd_ff;

   logic [2:0]  lod_e;
   logic [7:0]  sp_e;
   logic [15:0] ww_e;
   logic [15:0] wd_e;
   logic [18:0] vbase;
   logic [VW-1:0] vert;

   // pipe
   logic adv;
   logic take;
   logic [3:0]            f_v_ff;
   logic [SQRT_STEPS:0]   sq_v_ff;
   logic [DIV_STEPS:0]    dv_v_ff;

   in_type  in_in, in_ff;
   f1_type  f1_in, f1_ff;
   f2_type  f2_in, f2_ff;
   f3_type  f3_in, f3_ff;
   sq_type  sq_in [0:SQRT_STEPS];
   sq_type  sq_ff [0:SQRT_STEPS];
   dv_type  dv_in [0:DIV_STEPS];
   dv_type  dv_ff [0:DIV_STEPS];

   logic [HW:0]   dx;
   logic [HW:0]   dz;
   logic [8:0]    gx_s;
   logic [8:0]    gz_s;
   norm_type      nn;
   norm_type      nt;
   logic [TNUMW-1:0] nu;
   logic [TNUMW-1:0] nv;
   res_type       res;

   // output register and skid
   res_type out_ff;
   res_type skid_ff;
   logic    out_v_ff;
   logic    skid_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lod_ff  <= 3'd0;
         sp_ff   <= 8'd1;
         edge_ff <= 16'd256;
         ww_ff   <= 16'd4096;
         wd_ff   <= 16'd4096;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_LOD:        lod_ff  <= csr_wdata[2:0];
            CSR_SPACING:    sp_ff   <= csr_wdata[7:0];
            CSR_CHUNK_EDGE: edge_ff <= csr_wdata;
            CSR_WORLD_W:    ww_ff   <= csr_wdata;
            CSR_WORLD_D:    wd_ff   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      lod_e = (lod_ff > 3'(MAX_LOD)) ? 3'(MAX_LOD) : lod_ff;
      sp_e  = (sp_ff == '0) ? 8'd1 : sp_ff;
      ww_e  = (ww_ff == '0) ? 16'd1 : ww_ff;
      wd_e  = (wd_ff == '0) ? 16'd1 : wd_ff;
      vbase = 19'(sp_e) * 19'(VERT_SCALE);
      vert  = VW'(vbase) << lod_e;
   end

   assign adv       = !skid_v_ff;
   assign req_stall = skid_v_ff;
   assign take      = out_v_ff && !rsp_stall;

   assign in_in = '{hc: req_height_center, hl: req_height_left, hr: req_height_right,
                    hd: req_height_down, hu: req_height_up, cx: req_chunk_x,
                    cz: req_chunk_z, gx: req_grid_x, gz: req_grid_z};

   // stage 1: differences, vertical term, position products
   always_comb begin
      dx   = {in_ff.hl[HW-1], in_ff.hl} - {in_ff.hr[HW-1], in_ff.hr};
      dz   = {in_ff.hd[HW-1], in_ff.hd} - {in_ff.hu[HW-1], in_ff.hu};
      gx_s = (in_ff.gx > 9'(MAX_GRID_SIDE - 1)) ? 9'(MAX_GRID_SIDE - 1) : in_ff.gx;
      gz_s = (in_ff.gz > 9'(MAX_GRID_SIDE - 1)) ? 9'(MAX_GRID_SIDE - 1) : in_ff.gz;
      f1_in               = '0;
      f1_in.pass.pos_y    = in_ff.hc;
      f1_in.pass.neg_nx   = dx[HW];
      f1_in.pass.neg_nz   = dz[HW];
      // tangent y is right minus left, the opposite sign of dx
      f1_in.pass.neg_ty   = !dx[HW] && (dx != '0);
      f1_in.pass.hand_neg = !dz[HW];
      f1_in.mx   = dx[HW] ? MAGW'(-dx) : dx[MAGW-1:0];
      f1_in.mz   = dz[HW] ? MAGW'(-dz) : dz[MAGW-1:0];
      f1_in.vert = vert;
      f1_in.cxe  = 26'(in_ff.cx) * 26'(edge_ff);
      f1_in.cze  = 26'(in_ff.cz) * 26'(edge_ff);
      f1_in.gxs  = 17'(gx_s) * 17'(sp_e);
      f1_in.gzs  = 17'(gz_s) * 17'(sp_e);
   end

   // stage 2: squares and raw positions
   always_comb begin
      f2_in.pass = f1_ff.pass;
      f2_in.sqx  = SQW'(f1_ff.mx) * SQW'(f1_ff.mx);
      f2_in.sqz  = SQW'(f1_ff.mz) * SQW'(f1_ff.mz);
      f2_in.sqv  = SQW'(f1_ff.vert) * SQW'(f1_ff.vert);
      f2_in.mx   = f1_ff.mx;
      f2_in.mz   = f1_ff.mz;
      f2_in.vert = f1_ff.vert;
      f2_in.px   = POSW'(f1_ff.cxe) + (POSW'(f1_ff.gxs) << lod_e);
      f2_in.pz   = POSW'(f1_ff.cze) + (POSW'(f1_ff.gzs) << lod_e);
   end

   // stage 3: sums of squares, saturated position, texture dividends
   always_comb begin
      nu = TNUMW'({f2_ff.px, 16'b0}) + TNUMW'(ww_e >> 1);
      nv = TNUMW'({f2_ff.pz, 16'b0}) + TNUMW'(wd_e >> 1);
      f3_in.pass       = f2_ff.pass;
      f3_in.pass.pos_x = (f2_ff.px > POSW'(16'hFFFF)) ? 16'hFFFF : f2_ff.px[15:0];
      f3_in.pass.pos_z = (f2_ff.pz > POSW'(16'hFFFF)) ? 16'hFFFF : f2_ff.pz[15:0];
      f3_in.sn   = SUMW'(f2_ff.sqx) + SUMW'(f2_ff.sqv) + SUMW'(f2_ff.sqz);
      f3_in.st   = SUMW'(f2_ff.sqx) + SUMW'(f2_ff.sqv);
      f3_in.mx   = f2_ff.mx;
      f3_in.mz   = f2_ff.mz;
      f3_in.vert = f2_ff.vert;
      f3_in.tu.rem = nu;
      f3_in.tu.q   = '0;
      // quotient above one saturates
      f3_in.tu.sat = nu >= (TNUMW'({ww_e, 16'b0}) + TNUMW'(ww_e));
      f3_in.tv.rem = nv;
      f3_in.tv.q   = '0;
      f3_in.tv.sat = nv >= (TNUMW'({wd_e, 16'b0}) + TNUMW'(wd_e));
   end

   // root stage 0: normalise both sums, scale magnitudes by the same power of two
   always_comb begin
      nn = norm_shift(f3_ff.sn);
      nt = norm_shift(f3_ff.st);
      sq_in[0].pass = f3_ff.pass;
      sq_in[0].rn.x = nn.s;
      sq_in[0].rn.r = '0;
      sq_in[0].rt.x = nt.s;
      sq_in[0].rt.r = '0;
      sq_in[0].mnx  = ROOTW'(f3_ff.mx) << nn.k;
      sq_in[0].mny  = ROOTW'(f3_ff.vert) << nn.k;
      sq_in[0].mnz  = ROOTW'(f3_ff.mz) << nn.k;
      sq_in[0].mtx  = ROOTW'(f3_ff.vert) << nt.k;
      sq_in[0].mty  = ROOTW'(f3_ff.mx) << nt.k;
      sq_in[0].tu   = f3_ff.tu;
      sq_in[0].tv   = f3_ff.tv;
   end

   for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_root
      assign sq_in[j+1] = sq_stage(sq_ff[j], ww_e, wd_e, j);
   end

   // divide stage 0: rounded dividends, texture results settled
   always_comb begin
      dv_in[0].pass       = sq_ff[SQRT_STEPS].pass;
      dv_in[0].pass.tex_u = sq_ff[SQRT_STEPS].tu.sat ? UV_ONE : sq_ff[SQRT_STEPS].tu.q;
      dv_in[0].pass.tex_v = sq_ff[SQRT_STEPS].tv.sat ? UV_ONE : sq_ff[SQRT_STEPS].tv.q;
      dv_in[0].ln = sq_ff[SQRT_STEPS].rn.r[ROOTW-1:0];
      dv_in[0].lt = sq_ff[SQRT_STEPS].rt.r[ROOTW-1:0];
      dv_in[0].nx.rem = NUMW'({sq_ff[SQRT_STEPS].mnx, 15'b0}) + NUMW'(dv_in[0].ln >> 1);
      dv_in[0].ny.rem = NUMW'({sq_ff[SQRT_STEPS].mny, 15'b0}) + NUMW'(dv_in[0].ln >> 1);
      dv_in[0].nz.rem = NUMW'({sq_ff[SQRT_STEPS].mnz, 15'b0}) + NUMW'(dv_in[0].ln >> 1);
      dv_in[0].tx.rem = NUMW'({sq_ff[SQRT_STEPS].mtx, 15'b0}) + NUMW'(dv_in[0].lt >> 1);
      dv_in[0].ty.rem = NUMW'({sq_ff[SQRT_STEPS].mty, 15'b0}) + NUMW'(dv_in[0].lt >> 1);
      dv_in[0].nx.q = '0;
      dv_in[0].ny.q = '0;
      dv_in[0].nz.q = '0;
      dv_in[0].tx.q = '0;
      dv_in[0].ty.q = '0;
   end

   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
      assign dv_in[j+1] = dv_stage(dv_ff[j], j);
   end

   // final formatting
   always_comb begin
      res.pos_x    = dv_ff[DIV_STEPS].pass.pos_x;
      res.pos_y    = dv_ff[DIV_STEPS].pass.pos_y;
      res.pos_z    = dv_ff[DIV_STEPS].pass.pos_z;
      res.nrm_x    = to_q15(dv_ff[DIV_STEPS].nx.q, dv_ff[DIV_STEPS].pass.neg_nx);
      res.nrm_y    = dv_ff[DIV_STEPS].ny.q[QW-1] ? 15'h7FFF : dv_ff[DIV_STEPS].ny.q[14:0];
      res.nrm_z    = to_q15(dv_ff[DIV_STEPS].nz.q, dv_ff[DIV_STEPS].pass.neg_nz);
      res.tan_x    = to_q15(dv_ff[DIV_STEPS].tx.q, 1'b0);
      res.tan_y    = to_q15(dv_ff[DIV_STEPS].ty.q, dv_ff[DIV_STEPS].pass.neg_ty);
      res.tan_z    = '0;
      res.hand_neg = dv_ff[DIV_STEPS].pass.hand_neg;
      res.tex_u    = dv_ff[DIV_STEPS].pass.tex_u;
      res.tex_v    = dv_ff[DIV_STEPS].pass.tex_v;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_v_ff  <= '0;
         sq_v_ff <= '0;
         dv_v_ff <= '0;
      end else if (adv) begin
         f_v_ff  <= {f_v_ff[2:0], req_valid};
         sq_v_ff <= {sq_v_ff[SQRT_STEPS-1:0], f_v_ff[3]};
         dv_v_ff <= {dv_v_ff[DIV_STEPS-1:0], sq_v_ff[SQRT_STEPS]};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         in_ff <= in_in;
         f1_ff <= f1_in;
         f2_ff <= f2_in;
         f3_ff <= f3_in;
         sq_ff <= sq_in;
         dv_ff <= dv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (adv) begin
         if (!out_v_ff || take)
            out_v_ff <= dv_v_ff[DIV_STEPS];
         else
            skid_v_ff <= dv_v_ff[DIV_STEPS];
      end else if (take) begin
         out_v_ff  <= 1'b1;
         skid_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         if (!out_v_ff || take)
            out_ff <= res;
         else
            skid_ff <= res;
      end else if (take) begin
         out_ff <= skid_ff;
      end
   end

   assign rsp_valid               = out_v_ff;
   assign rsp_pos_x               = out_ff.pos_x;
   assign rsp_pos_y               = signed'(out_ff.pos_y);
   assign rsp_pos_z               = out_ff.pos_z;
   assign rsp_nrm_x               = signed'(out_ff.nrm_x);
   assign rsp_nrm_y               = out_ff.nrm_y;
   assign rsp_nrm_z               = signed'(out_ff.nrm_z);
   assign rsp_tan_x               = signed'(out_ff.tan_x);
   assign rsp_tan_y               = signed'(out_ff.tan_y);
   assign rsp_tan_z               = signed'(out_ff.tan_z);
   assign rsp_handedness_negative = out_ff.hand_neg;
   assign rsp_tex_u               = out_ff.tex_u;
   assign rsp_tex_v               = out_ff.tex_v;

   // a word in the skid implies one waiting in the output register
   `HVNT_ASSERT(a_skid_behind_out, skid_v_ff |-> out_v_ff, "skid full with output empty")
   // skid only drains on a taken word
   `HVNT_ASSERT(a_skid_drain, $fell(skid_v_ff) |-> $past(take), "skid drained without take")
   // vertical term is never zero so the normal keeps a positive y
   `HVNT_ASSERT(a_normal_y, out_v_ff |-> rsp_nrm_y != '0, "normal y is zero")
   `HVNT_ASSERT(a_tangent, out_v_ff |-> (!rsp_tan_x[15] && rsp_tan_z == '0), "tangent off plane")
   // a full skid freezes the pipe for at least the next edge's input
   `HVNT_ASSERT_NEXT(a_stall_hold, skid_v_ff && rsp_stall, req_stall, "input taken while frozen")

endmodule
